>>> src/uleb128_stream_decoder_core_assert.svh
// Assertion macros for the ULEB128 decoder RTL
`ifndef ULEB128_STREAM_DECODER_CORE_ASSERT_SVH
`define ULEB128_STREAM_DECODER_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define ULEB_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed: always");

// Antecedent in one cycle implies consequent in the next
`define ULEB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");

`endif

>>> src/uleb_pkg.sv
// Types, constants and helpers for the ULEB128 stream decoder
package uleb_pkg;

    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned GROUP_W   = 7;
    localparam int unsigned CONT_POS  = 7;
    localparam int unsigned MAX_BYTES = 10;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_NONCANON  = 2'd3
    } t_status;

    typedef struct packed {
        logic                 has_result;
        logic [VALUE_W-1:0]   value;
        t_status              status;
        logic [COUNT_W-1:0]   count;
    } t_step;

    // Shortest encoded length of a value: index of the top nonzero 7-bit group, plus one
    function automatic logic [COUNT_W-1:0] min_len(input logic [VALUE_W-1:0] v);
        logic [COUNT_W-1:0] n;
        n = COUNT_W'(1);
        for (int i = 1; i < MAX_BYTES; i++) begin
            if ((v >> (GROUP_W * i)) != '0) begin
                n = COUNT_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

>>> src/uleb128_stream_decoder_core.sv
// Top level of the unsigned LEB128 (64-bit) stream decoder
//
// Input channel: one encoded byte per request (i_data_byte, i_buffer_end marks
// the last byte available), accepted when i_in_valid is high and o_in_stall low.
// Output channel: one result per finished or failed value (o_value, o_status,
// o_byte_count), taken when o_out_valid is high and i_out_stall low.
// Status: ok, truncated, too long, or non-canonical; o_value is 0 unless ok.
// Continuation bytes that end nothing produce no result.
// Throughput: one byte per cycle, sustained while no result waits on a receiver
// stall. The byte goes into an input register, and shift/OR/length-check logic
// feeds the result register, which drives the outputs.
// Receiver stall: the result register holds; a byte that makes a result waits
// in the input register and raises o_in_stall, while bytes that make no result
// keep flowing into the accumulator.
// Reset (synchronous, active low): both registers empty, accumulator and
// byte count cleared, so the next byte starts a new value.
module uleb128_stream_decoder_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_buffer_end,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [uleb_pkg::VALUE_W-1:0]   o_value,
    output logic [1:0]                     o_status,
    output logic [uleb_pkg::COUNT_W-1:0]   o_byte_count
);
    import uleb_pkg::*;
    `include "uleb128_stream_decoder_core_assert.svh"

    logic       r_in_valid;
    logic       n_in_valid;
    logic [7:0] r_byte;
    logic       r_last;

    t_step      step;
    logic       out_free;
    logic       s1_fire;
    logic       in_accept;

    assign s1_fire    = r_in_valid && (out_free || !step.has_result);
    assign o_in_stall = r_in_valid && !s1_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid && !s1_fire;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_byte <= i_data_byte;
            r_last <= i_buffer_end;
        end
    end

    uleb_dec_unit u_dec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (s1_fire),
        .i_data_byte  (r_byte),
        .i_buffer_end (r_last),
        .o_step       (step)
    );

    uleb_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (s1_fire && step.has_result),
        .i_step       (step),
        .i_out_stall  (i_out_stall),
        .o_free       (out_free),
        .o_out_valid  (o_out_valid),
        .o_value      (o_value),
        .o_status     (o_status),
        .o_byte_count (o_byte_count)
    );

    // ok results are always in shortest form
    `ULEB_ASSERT_ALWAYS(a_ok_canonical,
        !(o_out_valid && o_status == ST_OK) || (min_len(o_value) == o_byte_count))
    // failed results carry a zero value
    `ULEB_ASSERT_ALWAYS(a_fail_zero,
        !(o_out_valid && o_status != ST_OK) || (o_value == '0))
    // truncation can only be reported before the tenth byte
    `ULEB_ASSERT_ALWAYS(a_trunc_count,
        !(o_out_valid && o_status == ST_TRUNCATED) || (o_byte_count < COUNT_W'(MAX_BYTES)))
    // input stalls only when a result is blocked behind a stalled output
    `ULEB_ASSERT_ALWAYS(a_stall_cause,
        !o_in_stall || (r_in_valid && o_out_valid && i_out_stall && step.has_result))
    // a blocked byte stays in the input register
    `ULEB_ASSERT_NEXT(a_stall_hold, o_in_stall, r_in_valid)

endmodule

>>> src/uleb_dec_unit.sv
// Decode state (accumulator, byte count) and the per-byte decode logic
module uleb_dec_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_buffer_end,
    output uleb_pkg::t_step       o_step
);
    import uleb_pkg::*;

    logic [VALUE_W-1:0] r_acc;
    logic [VALUE_W-1:0] n_acc;
    logic [COUNT_W-1:0] r_bytes_seen;
    logic [COUNT_W-1:0] n_bytes_seen;

    logic [6:0]         shamt;
    logic [VALUE_W-1:0] shifted;
    logic [VALUE_W-1:0] merged;
    logic [COUNT_W-1:0] count;
    logic               cont;

    // bytes_seen stays below MAX_BYTES, so the shift never reaches 64
    assign shamt   = 7'(r_bytes_seen) * 7'(GROUP_W);
    assign shifted = {{(VALUE_W-GROUP_W){1'b0}}, i_data_byte[GROUP_W-1:0]} << shamt;
    assign merged  = r_acc | shifted;
    assign count   = r_bytes_seen + COUNT_W'(1);
    assign cont    = i_data_byte[CONT_POS];

    always_comb begin
        o_step.has_result = 1'b1;
        o_step.value      = '0;
        o_step.status     = ST_OK;
        o_step.count      = count;
        priority if (!cont) begin
            if (min_len(merged) != count) begin
                o_step.status = ST_NONCANON;
            end else begin
                o_step.value  = merged;
            end
        end else if (count >= COUNT_W'(MAX_BYTES)) begin
            o_step.status = ST_TOO_LONG;
        end else if (i_buffer_end) begin
            o_step.status = ST_TRUNCATED;
        end else begin
            o_step.has_result = 1'b0;
        end
    end

    always_comb begin
        n_acc        = r_acc;
        n_bytes_seen = r_bytes_seen;
        if (i_fire) begin
            if (o_step.has_result) begin
                n_acc        = '0;
                n_bytes_seen = '0;
            end else begin
                n_acc        = merged;
                n_bytes_seen = count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_bytes_seen <= '0;
        end else begin
            r_acc        <= n_acc;
            r_bytes_seen <= n_bytes_seen;
        end
    end

endmodule

>>> src/uleb_out_reg.sv
// Result register on the output channel
module uleb_out_reg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  uleb_pkg::t_step                i_step,
    input  logic                           i_out_stall,
    output logic                           o_free,
    output logic                           o_out_valid,
    output logic [uleb_pkg::VALUE_W-1:0]   o_value,
    output logic [1:0]                     o_status,
    output logic [uleb_pkg::COUNT_W-1:0]   o_byte_count
);
    import uleb_pkg::*;

    logic               r_valid;
    logic               n_valid;
    logic [VALUE_W-1:0] r_value;
    t_status            r_status;
    logic [COUNT_W-1:0] r_count;

    assign o_free = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid && i_out_stall;
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value  <= i_step.value;
            r_status <= i_step.status;
            r_count  <= i_step.count;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_value      = r_value;
    assign o_status     = r_status;
    assign o_byte_count = r_count;

endmodule

>>> tb/uleb128_stream_decoder_core_tb.sv
// Self-checking testbench for the unsigned LEB128 stream decoder core
`timescale 1ns / 100ps

module uleb128_stream_decoder_core_tb;
    import uleb_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_BYTES  = 420;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic [VALUE_W-1:0] value;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_decoded;

    // Tracks the decoder state and the queue of decoded values still owed
    class uleb_scoreboard;
        logic [VALUE_W-1:0] acc;
        logic [COUNT_W-1:0] nbytes;
        t_decoded           decoded_q[$];
        int                 errors;

        function new();
            acc    = '0;
            nbytes = '0;
            errors = 0;
        endfunction

        function int shortest_len(logic [VALUE_W-1:0] v);
            int n;
            n = 1;
            v = v >> GROUP_W;
            while (v != '0) begin
                v = v >> GROUP_W;
                n++;
            end
            return n;
        endfunction

        function void note_request(logic [7:0] b, logic last);
            logic [VALUE_W-1:0] payload;
            int                 cnt;
            t_decoded           d;
            logic               done;
            payload = {{(VALUE_W-GROUP_W){1'b0}}, b[GROUP_W-1:0]};
            // shift never exceeds 63, bits pushed past the top are dropped
            acc     = acc | (payload << (int'(nbytes) * GROUP_W));
            cnt     = int'(nbytes) + 1;
            d.value = '0;
            d.count = COUNT_W'(cnt);
            done    = 1'b1;
            if (!b[CONT_POS]) begin
                if (shortest_len(acc) != cnt) begin
                    d.status = ST_NONCANON;
                end else begin
                    d.status = ST_OK;
                    d.value  = acc;
                end
            end else if (cnt >= MAX_BYTES) begin
                d.status = ST_TOO_LONG;
            end else if (last) begin
                d.status = ST_TRUNCATED;
            end else begin
                done = 1'b0;
            end
            if (done) begin
                decoded_q.push_back(d);
                acc    = '0;
                nbytes = '0;
            end else begin
                nbytes = COUNT_W'(cnt);
            end
        endfunction

        function void check_result(logic [VALUE_W-1:0] v, logic [1:0] s,
                                   logic [COUNT_W-1:0] c);
            t_decoded d;
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result value=%h status=%0d count=%0d",
                         $time, v, s, c);
                errors++;
                return;
            end
            d = decoded_q.pop_front();
            if (v !== d.value) begin
                $display("%0t: value mismatch: expected %h, actual %h", $time, d.value, v);
                errors++;
            end
            if (s !== d.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, d.status, s);
                errors++;
            end
            if (c !== d.count) begin
                $display("%0t: byte_count mismatch: expected %0d, actual %0d",
                         $time, d.count, c);
                errors++;
            end
        endfunction

        function int outstanding();
            return decoded_q.size();
        endfunction
    endclass

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic [7:0]           i_data_byte  = 8'h00;
    logic                 i_buffer_end = 1'b0;
    logic                 i_out_stall  = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [VALUE_W-1:0]   o_value;
    logic [1:0]           o_status;
    logic [COUNT_W-1:0]   o_byte_count;

    uleb_scoreboard board = new();
    int  sender_idle_pct = 0;
    int  recv_stall_pct  = 0;
    bit  hold_req        = 1'b0;
    int  hold_left       = 0;
    int  bytes_sent      = 0;
    int  quiet_cycles    = 0;

    uleb128_stream_decoder_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_buffer_end (i_buffer_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_status     (o_status),
        .o_byte_count (o_byte_count)
    );

    always #5 i_clk = ~i_clk;

    // Result side: check taken results, then pick the stall for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            board.check_result(o_value, o_status, o_byte_count);
        end
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: timeout, no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("uleb128_stream_decoder_core_tb: errors");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_buffer_end <= last;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        board.note_request(b, last);
        bytes_sent++;
    endtask

    // Mostly well-formed values with random content, some overlong runs and noise
    task automatic send_random_value();
        int         kind;
        int         len;
        logic [6:0] pay;
        kind = $urandom_range(99);
        if (kind < 75) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(10, 6) : $urandom_range(5, 1);
            for (int i = 1; i < len; i++) begin
                // early buffer end cuts the value short
                if ($urandom_range(19) == 0) begin
                    send_byte({1'b1, 7'($urandom)}, 1'b1);
                    return;
                end
                send_byte({1'b1, 7'($urandom)}, 1'b0);
            end
            pay = 7'($urandom);
            if (len > 1 && $urandom_range(4) != 0) begin
                // keep the top group nonzero so the encoding is shortest form
                if (len == MAX_BYTES) pay[0] = 1'b1;
                else if (pay == 7'd0) pay = 7'd1;
            end
            send_byte({1'b0, pay}, 1'($urandom));
        end else if (kind < 85) begin
            repeat (MAX_BYTES - 1) send_byte({1'b1, 7'($urandom)}, 1'b0);
            send_byte({1'b1, 7'($urandom)}, 1'($urandom));
        end else begin
            send_byte(8'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        int goal;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b1);                 // terminator with buffer end
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);                 // zero top group: not shortest form
        send_byte(8'h00, 1'b0);
        send_byte(8'h85, 1'b1);                 // truncated
        repeat (MAX_BYTES - 1) send_byte(8'hff, 1'b0);
        send_byte(8'h01, 1'b0);                 // all ones, ten bytes
        repeat (MAX_BYTES - 1) send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);                 // too long wins over truncated

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                    hold_req        = 1'b1;     // long receiver hold-off fills the block
                end
                1: begin
                    sender_idle_pct = 65;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 65;
                end
                default: begin
                    sender_idle_pct = 24;
                    recv_stall_pct  = 24;
                end
            endcase
            goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal) send_random_value();
        end

        i_in_valid     <= 1'b0;
        recv_stall_pct  = 0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("uleb128_stream_decoder_core_tb: clean");
        end else begin
            $display("uleb128_stream_decoder_core_tb: errors");
        end
        $finish;
    end

endmodule
